[hw/rtl/chb_pkg.sv]
// chb_pkg: shared types and constants for the cutpoint bucket histogram
// no dependencies; used by every other file of the block

package chb_pkg;

  // sizing of the histogram
  localparam int MAX_CUTS   = 7;
  localparam int COUNT_BITS = 32;
  localparam int NBUCKETS   = MAX_CUTS + 1;
  localparam int BKT_W      = $clog2(NBUCKETS);

  // field widths of the request and result channels
  localparam int OP_W     = 2;
  localparam int SAMPLE_W = 32;
  localparam int BUCKET_W = 3;
  localparam int RES_W    = 32;

  // configuration port
  localparam int NREGS    = 1 + MAX_CUTS;
  localparam int REG_IDX_W = $clog2(NREGS);
  localparam int PADDR_W  = REG_IDX_W + 2;
  localparam int PDATA_W  = 32;
  localparam int NCUTS_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_NUM_CUTS  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CUT_FIRST = REG_IDX_W'(1);
  localparam logic [NCUTS_W-1:0]   NUM_CUTS_RST  = NCUTS_W'(1);

  typedef logic [COUNT_BITS-1:0] count_t;

  // operation codes; the unused code behaves as a read
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // configuration seen by the classifier
  typedef struct packed {
    logic [NCUTS_W-1:0]                 num_cuts;
    logic [MAX_CUTS-1:0][SAMPLE_W-1:0]  cuts;
  } cfg_t;

  // request after classification
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [BUCKET_W-1:0] sel;
  } stage_t;

endpackage

[hw/rtl/chb_if.sv]
// chb_in_if and chb_out_if: valid/ready request channels of the histogram
// depends on chb_pkg for field widths

interface chb_in_if;
  logic                              valid;
  logic                              ready;
  logic [chb_pkg::OP_W-1:0]          operation;
  logic signed [chb_pkg::SAMPLE_W-1:0] sample;
  logic [chb_pkg::BUCKET_W-1:0]      bucket_index;

  modport source (output valid, operation, sample, bucket_index, input ready);
  modport sink   (input valid, operation, sample, bucket_index, output ready);
endinterface

interface chb_out_if;
  logic                          valid;
  logic                          ready;
  logic [chb_pkg::BUCKET_W-1:0]  bucket;
  logic [chb_pkg::RES_W-1:0]     bucket_count;
  logic [chb_pkg::BUCKET_W-1:0]  mode_bucket;
  logic [chb_pkg::RES_W-1:0]     mode_count;

  modport source (output valid, bucket, bucket_count, mode_bucket, mode_count,
                  input ready);
  modport sink   (input valid, bucket, bucket_count, mode_bucket, mode_count,
                  output ready);
endinterface

[hw/rtl/cutpoint_bucket_histogram_unit.sv]
// cutpoint_bucket_histogram_unit: top level of the cutpoint bucket histogram
// depends on chb_pkg, chb_if, chb_cfg_regs, chb_classify and chb_count
// results are valid after requests pass the input, bucket and result registers
// throughput: one request per cycle while results are taken; cutpoint compares
//   and counter update take one register stage each; mode updates with the counter
// reset: synchronous active-low rst_n clears counts and mode, sets num_cuts 1
//   and all cutpoints 0; no clearing pass, requests are taken right after reset

module cutpoint_bucket_histogram_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  chb_in_if.sink                        in_req,
  chb_out_if.source                     out_req,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chb_pkg::PADDR_W-1:0]   paddr,
  input  logic [chb_pkg::PDATA_W-1:0]   pwdata,
  output logic [chb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  chb_pkg::cfg_t   cfg;
  chb_pkg::stage_t st;
  logic            st_valid;
  logic            st_ready;

  // configuration registers
  chb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // bucket selection
  chb_classify u_classify (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_req   (in_req),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st       (st)
  );

  // counting and mode
  chb_count u_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .st       (st),
    .out_req  (out_req)
  );

endmodule

[hw/rtl/chb_cfg_regs.sv]
// chb_cfg_regs: APB-style register file holding cutpoint count and cutpoints
// depends on chb_pkg

module chb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [chb_pkg::PADDR_W-1:0]   paddr,
  input  logic [chb_pkg::PDATA_W-1:0]   pwdata,
  output logic [chb_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output chb_pkg::cfg_t                 cfg
);

  logic [chb_pkg::NCUTS_W-1:0]                         num_cuts_r;
  logic [chb_pkg::MAX_CUTS-1:0][chb_pkg::SAMPLE_W-1:0] cuts_r;
  logic [chb_pkg::REG_IDX_W-1:0]                       reg_idx;
  logic                                                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[chb_pkg::PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_cuts_r <= chb_pkg::NUM_CUTS_RST;
      cuts_r     <= '0;
    end else if (wr_en) begin
      if (reg_idx == chb_pkg::REG_NUM_CUTS) begin
        num_cuts_r <= pwdata[chb_pkg::NCUTS_W-1:0];
      end
      for (int i = 0; i < chb_pkg::MAX_CUTS; i++) begin
        if (reg_idx == chb_pkg::REG_CUT_FIRST + chb_pkg::REG_IDX_W'(i)) begin
          cuts_r[i] <= pwdata[chb_pkg::SAMPLE_W-1:0];
        end
      end
    end
  end

  // read-back mux
  always_comb begin
    prdata = '0;
    if (reg_idx == chb_pkg::REG_NUM_CUTS) begin
      prdata = chb_pkg::PDATA_W'(num_cuts_r);
    end
    for (int i = 0; i < chb_pkg::MAX_CUTS; i++) begin
      if (reg_idx == chb_pkg::REG_CUT_FIRST + chb_pkg::REG_IDX_W'(i)) begin
        prdata = chb_pkg::PDATA_W'(cuts_r[i]);
      end
    end
  end

  assign cfg.num_cuts = num_cuts_r;
  assign cfg.cuts     = cuts_r;

endmodule

[hw/rtl/chb_classify.sv]
// chb_classify: input register, parallel cutpoint compare and bucket register
// depends on chb_pkg and chb_in_if

module chb_classify (
  input  logic             clk,
  input  logic             rst_n,
  input  chb_pkg::cfg_t    cfg,
  chb_in_if.sink           in_req,
  output logic             st_valid,
  input  logic             st_ready,
  output chb_pkg::stage_t  st
);

  logic                                a_v_r;
  logic [chb_pkg::OP_W-1:0]            a_op_r;
  logic signed [chb_pkg::SAMPLE_W-1:0] a_sample_r;
  logic [chb_pkg::BUCKET_W-1:0]        a_idx_r;
  logic                                b_v_r;
  chb_pkg::stage_t                     b_st_r;
  chb_pkg::stage_t                     b_st_nxt;
  logic                                a_adv;
  logic                                b_free;
  logic [chb_pkg::BUCKET_W-1:0]        below;
  logic [chb_pkg::NCUTS_W-1:0]         n_act;

  assign b_free       = !b_v_r || st_ready;
  assign a_adv        = a_v_r && b_free;
  assign in_req.ready = !a_v_r || b_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (in_req.ready) begin
      a_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      a_op_r     <= in_req.operation;
      a_sample_r <= in_req.sample;
      a_idx_r    <= in_req.bucket_index;
    end
  end

  // active cutpoints, limited to the number implemented
  always_comb begin
    if (int'(cfg.num_cuts) > chb_pkg::MAX_CUTS) begin
      n_act = chb_pkg::NCUTS_W'(chb_pkg::MAX_CUTS);
    end else begin
      n_act = cfg.num_cuts;
    end
  end

  // count active cutpoints strictly below the sample
  always_comb begin
    below = '0;
    for (int i = 0; i < chb_pkg::MAX_CUTS; i++) begin
      if ((i < int'(n_act)) && ($signed(cfg.cuts[i]) < a_sample_r)) begin
        below = below + chb_pkg::BUCKET_W'(1);
      end
    end
  end

  // bucket selected by the request
  always_comb begin
    b_st_nxt.op = a_op_r;
    case (a_op_r)
      chb_pkg::OP_CLEAR: b_st_nxt.sel = '0;
      chb_pkg::OP_ADD:   b_st_nxt.sel = below;
      default:           b_st_nxt.sel = a_idx_r;
    endcase
  end

  // bucket register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_free) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_st_r <= b_st_nxt;
    end
  end

  assign st_valid = b_v_r;
  assign st       = b_st_r;

endmodule

[hw/rtl/chb_count.sv]
// chb_count: bucket counters, running mode and result register
// depends on chb_pkg and chb_out_if

module chb_count (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             st_valid,
  output logic             st_ready,
  input  chb_pkg::stage_t  st,
  chb_out_if.source        out_req
);

  chb_pkg::count_t                 counts_r [chb_pkg::NBUCKETS];
  chb_pkg::count_t                 mode_val_r;
  chb_pkg::count_t                 mode_val_nxt;
  logic [chb_pkg::BUCKET_W-1:0]    mode_idx_r;
  logic [chb_pkg::BUCKET_W-1:0]    mode_idx_nxt;
  logic                            out_v_r;
  logic [chb_pkg::BUCKET_W-1:0]    res_bkt_r;
  logic [chb_pkg::BUCKET_W-1:0]    res_bkt_nxt;
  chb_pkg::count_t                 res_cnt_r;
  chb_pkg::count_t                 res_cnt_nxt;
  logic                            fire;
  logic                            in_range;
  logic [chb_pkg::BKT_W-1:0]       idx;
  chb_pkg::count_t                 cur;
  chb_pkg::count_t                 inc;
  logic                            do_clear;
  logic                            do_inc;

  assign st_ready = !out_v_r || out_req.ready;
  assign fire     = st_valid && st_ready;
  assign in_range = int'(st.sel) < chb_pkg::NBUCKETS;
  assign idx      = st.sel[chb_pkg::BKT_W-1:0];
  assign cur      = in_range ? counts_r[idx] : '0;
  assign inc      = cur + chb_pkg::COUNT_BITS'(1);

  // counter update and mode tracking
  always_comb begin
    do_clear     = 1'b0;
    do_inc       = 1'b0;
    mode_val_nxt = mode_val_r;
    mode_idx_nxt = mode_idx_r;
    res_bkt_nxt  = st.sel;
    res_cnt_nxt  = cur;
    case (st.op)
      chb_pkg::OP_CLEAR: begin
        do_clear     = 1'b1;
        mode_val_nxt = '0;
        mode_idx_nxt = '0;
        res_bkt_nxt  = '0;
        res_cnt_nxt  = '0;
      end
      chb_pkg::OP_ADD: begin
        // saturated counts stay put and leave the mode alone
        if (in_range && (cur != '1)) begin
          do_inc      = 1'b1;
          res_cnt_nxt = inc;
          if ((inc > mode_val_r) || ((inc == mode_val_r) && (st.sel < mode_idx_r))) begin
            mode_val_nxt = inc;
            mode_idx_nxt = st.sel;
          end
        end
      end
      default: begin
        res_cnt_nxt = cur;
      end
    endcase
  end

  // counters and mode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < chb_pkg::NBUCKETS; i++) begin
        counts_r[i] <= '0;
      end
      mode_val_r <= '0;
      mode_idx_r <= '0;
    end else if (fire) begin
      if (do_clear) begin
        for (int i = 0; i < chb_pkg::NBUCKETS; i++) begin
          counts_r[i] <= '0;
        end
      end else if (do_inc) begin
        counts_r[idx] <= inc;
      end
      mode_val_r <= mode_val_nxt;
      mode_idx_r <= mode_idx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (st_ready) begin
      out_v_r <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_bkt_r <= res_bkt_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  assign out_req.valid        = out_v_r;
  assign out_req.bucket       = res_bkt_r;
  assign out_req.bucket_count = chb_pkg::RES_W'(res_cnt_r);
  assign out_req.mode_bucket  = mode_idx_r;
  assign out_req.mode_count   = chb_pkg::RES_W'(mode_val_r);

endmodule

[hw/rtl/chb_checker.sv]
// chb_checker: port-level assertions for the histogram, bound to the top level
// depends on chb_pkg and cutpoint_bucket_histogram_unit

module chb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [chb_pkg::BUCKET_W-1:0]  bucket,
  input logic [chb_pkg::RES_W-1:0]     bucket_count,
  input logic [chb_pkg::BUCKET_W-1:0]  mode_bucket,
  input logic [chb_pkg::RES_W-1:0]     mode_count
);

  // nothing comes out of the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bucket) && $stable(bucket_count)
      && $stable(mode_bucket) && $stable(mode_count))
    else $error("stalled result changed");

  // no bucket ever exceeds the mode count
  a_mode_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> bucket_count <= mode_count)
    else $error("bucket count above mode count");

  // ties go to the lowest bucket
  a_mode_lowest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (bucket_count == mode_count) |-> mode_bucket <= bucket)
    else $error("mode is not the lowest bucket with the largest count");

endmodule

bind cutpoint_bucket_histogram_unit chb_checker u_chb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_req.valid),
  .out_ready    (out_req.ready),
  .bucket       (out_req.bucket),
  .bucket_count (out_req.bucket_count),
  .mode_bucket  (out_req.mode_bucket),
  .mode_count   (out_req.mode_count)
);

[test/tb_cutpoint_bucket_histogram_unit.sv]
// tb_cutpoint_bucket_histogram_unit: self-checking bench for the cutpoint bucket histogram
// drives requests and register writes, predicts or looks up every result and compares it field by field
// depends on chb_pkg, chb_if and cutpoint_bucket_histogram_unit from the rtl

module tb_cutpoint_bucket_histogram_unit;

  localparam int HALF_PERIOD  = 5;
  localparam int LATENCY      = 2;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 180;
  localparam int REPORT_MAX   = 40;

  // spare operation code, handled by the block as a read
  localparam logic [chb_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  // register indexes of the cutpoints
  localparam logic [chb_pkg::REG_IDX_W-1:0] REG_CUT_A = chb_pkg::REG_CUT_FIRST;
  localparam logic [chb_pkg::REG_IDX_W-1:0] REG_CUT_B = chb_pkg::REG_CUT_FIRST + 3'd1;
  localparam logic [chb_pkg::REG_IDX_W-1:0] REG_CUT_C = chb_pkg::REG_CUT_FIRST + 3'd2;
  localparam logic [chb_pkg::REG_IDX_W-1:0] REG_CUT_D = chb_pkg::REG_CUT_FIRST + 3'd3;
  localparam logic [chb_pkg::REG_IDX_W-1:0] REG_CUT_E = chb_pkg::REG_CUT_FIRST + 3'd4;
  localparam logic [chb_pkg::REG_IDX_W-1:0] REG_CUT_F = chb_pkg::REG_CUT_FIRST + 3'd5;
  localparam logic [chb_pkg::REG_IDX_W-1:0] REG_CUT_G = chb_pkg::REG_CUT_FIRST + 3'd6;

  // extremes of a signed q16.16 value
  localparam logic [chb_pkg::SAMPLE_W-1:0] Q_MIN = 32'h8000_0000;
  localparam logic [chb_pkg::SAMPLE_W-1:0] Q_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [chb_pkg::BUCKET_W-1:0] bucket;
    logic [chb_pkg::RES_W-1:0]    count;
    logic [chb_pkg::BUCKET_W-1:0] mode_bkt;
    logic [chb_pkg::RES_W-1:0]    mode_cnt;
  } hist_res_t;

  // one row of the directed part: a request, or a register write
  typedef struct packed {
    bit                           is_write;
    logic [chb_pkg::OP_W-1:0]     op;
    logic [chb_pkg::SAMPLE_W-1:0] data;
    logic [chb_pkg::BUCKET_W-1:0] idx;
    bit                           typed;
    hist_res_t                    want;
  } dir_row_t;

  localparam int DIR_N = 30;
  localparam dir_row_t DIR_ROWS [0:DIR_N-1] = '{
    // reset settings: one cutpoint at zero
    '{1'b0, chb_pkg::OP_READ,  32'd0,         3'd0, 1'b1, '{3'd0, 32'd0, 3'd0, 32'd0}},
    '{1'b0, OP_SPARE,          32'd0,         3'd5, 1'b1, '{3'd5, 32'd0, 3'd0, 32'd0}},
    '{1'b0, chb_pkg::OP_ADD,   Q_MIN,         3'd0, 1'b1, '{3'd0, 32'd1, 3'd0, 32'd1}},
    '{1'b0, chb_pkg::OP_ADD,   Q_MAX,         3'd0, 1'b1, '{3'd1, 32'd1, 3'd0, 32'd1}},
    '{1'b0, chb_pkg::OP_ADD,   32'd0,         3'd0, 1'b1, '{3'd0, 32'd2, 3'd0, 32'd2}},
    '{1'b0, chb_pkg::OP_ADD,   32'd1,         3'd0, 1'b1, '{3'd1, 32'd2, 3'd0, 32'd2}},
    '{1'b0, chb_pkg::OP_ADD,   32'd1,         3'd0, 1'b1, '{3'd1, 32'd3, 3'd1, 32'd3}},
    '{1'b0, chb_pkg::OP_READ,  32'd0,         3'd7, 1'b1, '{3'd7, 32'd0, 3'd1, 32'd3}},
    '{1'b0, chb_pkg::OP_CLEAR, 32'hFFFF_FFFF, 3'd7, 1'b1, '{3'd0, 32'd0, 3'd0, 32'd0}},
    '{1'b0, chb_pkg::OP_READ,  32'd0,         3'd1, 1'b1, '{3'd1, 32'd0, 3'd0, 32'd0}},
    // all cutpoints in use, extremes and duplicates among them
    '{1'b1, chb_pkg::OP_CLEAR, 32'd7,         chb_pkg::REG_NUM_CUTS, 1'b0, '0},
    '{1'b1, chb_pkg::OP_CLEAR, Q_MIN,         REG_CUT_A, 1'b0, '0},
    '{1'b1, chb_pkg::OP_CLEAR, Q_MAX,         REG_CUT_B, 1'b0, '0},
    '{1'b1, chb_pkg::OP_CLEAR, 32'd0,         REG_CUT_C, 1'b0, '0},
    '{1'b1, chb_pkg::OP_CLEAR, 32'hFFFF_0000, REG_CUT_D, 1'b0, '0},
    '{1'b1, chb_pkg::OP_CLEAR, 32'h0001_0000, REG_CUT_E, 1'b0, '0},
    '{1'b1, chb_pkg::OP_CLEAR, 32'h0001_0000, REG_CUT_F, 1'b0, '0},
    '{1'b1, chb_pkg::OP_CLEAR, 32'hFFFF_FFFF, REG_CUT_G, 1'b0, '0},
    '{1'b0, chb_pkg::OP_ADD,   Q_MIN,         3'd0, 1'b0, '0},
    '{1'b0, chb_pkg::OP_ADD,   Q_MAX,         3'd0, 1'b0, '0},
    '{1'b0, chb_pkg::OP_ADD,   32'h8000_0001, 3'd0, 1'b0, '0},
    '{1'b0, chb_pkg::OP_ADD,   32'h0001_0000, 3'd0, 1'b0, '0},
    '{1'b0, chb_pkg::OP_ADD,   32'h0001_0001, 3'd0, 1'b0, '0},
    '{1'b0, chb_pkg::OP_ADD,   32'd0,         3'd0, 1'b0, '0},
    '{1'b0, chb_pkg::OP_READ,  32'd0,         3'd6, 1'b0, '0},
    // no cutpoint in use: every sample to bucket zero, higher buckets keep counts
    '{1'b1, chb_pkg::OP_CLEAR, 32'd0,         chb_pkg::REG_NUM_CUTS, 1'b0, '0},
    '{1'b0, chb_pkg::OP_ADD,   Q_MAX,         3'd0, 1'b0, '0},
    '{1'b0, chb_pkg::OP_ADD,   32'h1234_5678, 3'd0, 1'b0, '0},
    '{1'b0, chb_pkg::OP_READ,  32'd0,         3'd6, 1'b0, '0},
    '{1'b0, OP_SPARE,          32'd0,         3'd6, 1'b0, '0}
  };

  logic clk;
  logic rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [chb_pkg::PADDR_W-1:0] paddr;
  logic [chb_pkg::PDATA_W-1:0] pwdata;
  logic [chb_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  chb_in_if  in_req_if ();
  chb_out_if out_req_if ();

  cutpoint_bucket_histogram_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req_if),
    .out_req (out_req_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // histogram state and settings as the bench sees them
  chb_pkg::count_t                     bkt_cnt [chb_pkg::NBUCKETS];
  logic [chb_pkg::BKT_W-1:0]           top_bkt;
  chb_pkg::count_t                     top_cnt;
  logic [chb_pkg::NCUTS_W-1:0]         cuts_used;
  logic signed [chb_pkg::SAMPLE_W-1:0] cut_pt [chb_pkg::MAX_CUTS];

  hist_res_t   hist_expected [$];
  int          mismatches;
  int unsigned cycle_no = 0;
  int          burst_left;
  bit          no_gaps;
  int          holds_asked;

  // clock
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // bin one request and update the counts and the running mode
  function automatic hist_res_t bin_and_count(logic [chb_pkg::OP_W-1:0] op,
                                              logic signed [chb_pkg::SAMPLE_W-1:0] smp,
                                              logic [chb_pkg::BUCKET_W-1:0] idx);
    hist_res_t r;
    int        n;
    int        b;
    int        i;
    r = '0;
    b = 0;
    case (op)
      chb_pkg::OP_CLEAR: begin
        for (i = 0; i < chb_pkg::NBUCKETS; i++) bkt_cnt[i] = '0;
        top_bkt = '0;
        top_cnt = '0;
      end
      chb_pkg::OP_ADD: begin
        n = (cuts_used > chb_pkg::MAX_CUTS) ? chb_pkg::MAX_CUTS : int'(cuts_used);
        for (i = 0; i < n; i++)
          if (cut_pt[i] < smp) b++;
        // saturated count stays put, and so does the mode
        if (bkt_cnt[b] != '1) begin
          bkt_cnt[b] = bkt_cnt[b] + chb_pkg::count_t'(1);
          if (bkt_cnt[b] > top_cnt || (bkt_cnt[b] == top_cnt && b < top_bkt)) begin
            top_cnt = bkt_cnt[b];
            top_bkt = chb_pkg::BKT_W'(b);
          end
        end
        r.bucket = chb_pkg::BUCKET_W'(b);
        r.count  = chb_pkg::RES_W'(bkt_cnt[b]);
      end
      default: begin
        r.bucket = idx;
        r.count  = chb_pkg::RES_W'(bkt_cnt[idx]);
      end
    endcase
    r.mode_bkt = chb_pkg::BUCKET_W'(top_bkt);
    r.mode_cnt = chb_pkg::RES_W'(top_cnt);
    return r;
  endfunction

  // random q16.16 value: extremes, anything, or close to zero
  function automatic logic [chb_pkg::SAMPLE_W-1:0] pick_q16();
    case ($urandom_range(0, 7))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(0, 32'h6_0000)) - 32'h3_0000;
    endcase
  endfunction

  // random sample, often right on or next to a cutpoint
  function automatic logic [chb_pkg::SAMPLE_W-1:0] pick_sample();
    if ($urandom_range(0, 2) == 0)
      return 32'(cut_pt[$urandom_range(0, chb_pkg::MAX_CUTS - 1)])
             + 32'($urandom_range(0, 2)) - 32'd1;
    return pick_q16();
  endfunction

  // one request through the input channel, sent in bursts with gaps between unless no_gaps is set
  task automatic send_req(input logic [chb_pkg::OP_W-1:0] op,
                          input logic [chb_pkg::SAMPLE_W-1:0] smp,
                          input logic [chb_pkg::BUCKET_W-1:0] idx, input bit typed,
                          input hist_res_t want);
    hist_res_t r;
    int        gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_req_if.valid        <= 1'b1;
    in_req_if.operation    <= op;
    in_req_if.sample       <= smp;
    in_req_if.bucket_index <= idx;
    do @(posedge clk); while (!in_req_if.ready);
    r = bin_and_count(op, smp, idx);
    hist_expected.insert(hist_expected.size(), typed ? want : r);
    @(negedge clk);
  endtask

  // register write, only once all results are in
  task automatic reg_write(input logic [chb_pkg::REG_IDX_W-1:0] reg_idx,
                           input logic [chb_pkg::PDATA_W-1:0] value);
    in_req_if.valid <= 1'b0;
    burst_left = 0;
    while (hist_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == chb_pkg::REG_NUM_CUTS)
      cuts_used = value[chb_pkg::NCUTS_W-1:0];
    else
      cut_pt[reg_idx - chb_pkg::REG_CUT_FIRST] = value;
  endtask

  function automatic void check_field(string what, logic [chb_pkg::RES_W-1:0] want,
                                      logic [chb_pkg::RES_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    hist_res_t want;
    if (rst_n && out_req_if.valid && out_req_if.ready) begin
      if (hist_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with no request pending, expected none, got bucket %0d",
                   $time, out_req_if.bucket);
      end else begin
        want = hist_expected.pop_front();
        check_field("bucket", chb_pkg::RES_W'(want.bucket),
                    chb_pkg::RES_W'(out_req_if.bucket));
        check_field("bucket_count", want.count, out_req_if.bucket_count);
        check_field("mode_bucket", chb_pkg::RES_W'(want.mode_bkt),
                    chb_pkg::RES_W'(out_req_if.mode_bucket));
        check_field("mode_count", want.mode_cnt, out_req_if.mode_count);
      end
    end
  end

  // receiver: stall pattern changes every so often, plus long hold-offs on demand
  initial begin
    int pat;
    int pat_left;
    int hold_left;
    int holds_done;
    bit rdy;
    pat        = 0;
    pat_left   = 0;
    hold_left  = 0;
    holds_done = 0;
    out_req_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat      = $urandom_range(0, 3);
          pat_left = $urandom_range(40, 160);
        end
        pat_left--;
        case (pat)
          0:       rdy = 1'b1;
          1:       rdy = $urandom_range(0, 1);
          2:       rdy = (pat_left % 4) == 0;
          default: rdy = $urandom_range(0, 4) == 0;
        endcase
      end
      out_req_if.ready <= rdy;
    end
  end

  // stimulus
  initial begin
    logic [chb_pkg::OP_W-1:0] op;
    int                       pick;
    int                       row;
    int                       ph;
    int                       k;
    mismatches  = 0;
    burst_left  = 0;
    no_gaps     = 1'b0;
    holds_asked = 0;
    rst_n       = 1'b0;
    in_req_if.valid        = 1'b0;
    in_req_if.operation    = chb_pkg::OP_CLEAR;
    in_req_if.sample       = '0;
    in_req_if.bucket_index = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    // state after reset
    cuts_used = chb_pkg::NUM_CUTS_RST;
    for (k = 0; k < chb_pkg::MAX_CUTS; k++) cut_pt[k] = '0;
    for (k = 0; k < chb_pkg::NBUCKETS; k++) bkt_cnt[k] = '0;
    top_bkt = '0;
    top_cnt = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (row = 0; row < DIR_N; row++) begin
      if (DIR_ROWS[row].is_write)
        reg_write(DIR_ROWS[row].idx, DIR_ROWS[row].data);
      else
        send_req(DIR_ROWS[row].op, DIR_ROWS[row].data, DIR_ROWS[row].idx,
                 DIR_ROWS[row].typed, DIR_ROWS[row].want);
    end

    // random phases, each with fresh cutpoints
    for (ph = 0; ph < PHASES; ph++) begin
      reg_write(chb_pkg::REG_NUM_CUTS,
                (ph == 0) ? 32'd7 : (ph == 1) ? 32'd0 : $urandom_range(0, 7));
      for (k = 0; k < chb_pkg::MAX_CUTS; k++)
        reg_write(chb_pkg::REG_CUT_FIRST + chb_pkg::REG_IDX_W'(k), pick_q16());
      no_gaps = (ph == 3) || ($urandom_range(0, 3) == 0);
      // receiver goes quiet while requests keep coming
      if (ph == 3) holds_asked++;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2)       op = chb_pkg::OP_CLEAR;
        else if (pick < 70) op = chb_pkg::OP_ADD;
        else if (pick < 92) op = chb_pkg::OP_READ;
        else                op = OP_SPARE;
        send_req(op, pick_sample(),
                 chb_pkg::BUCKET_W'($urandom_range(0, chb_pkg::NBUCKETS - 1)), 1'b0, '0);
      end
    end

    // drain and settle
    in_req_if.valid <= 1'b0;
    while (hist_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && hist_expected.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[cutpoint_bucket_histogram_unit.f]
hw/rtl/chb_pkg.sv
hw/rtl/chb_if.sv
hw/rtl/chb_cfg_regs.sv
hw/rtl/chb_classify.sv
hw/rtl/chb_count.sv
hw/rtl/cutpoint_bucket_histogram_unit.sv
hw/rtl/chb_checker.sv
test/tb_cutpoint_bucket_histogram_unit.sv
